/* rtl/dgjs_pkg.sv */
package dgjs_pkg;

	localparam int MAX_JOBS_DEF      = 256;
	localparam int DURATION_BITS_DEF = 32;
	localparam int TOTAL_W           = 48;
	localparam int DUR_IN_W          = 32;
	localparam int COUNT_OUT_W       = 9;

	typedef struct packed {
		logic [DUR_IN_W-1:0] duration;
		logic [TOTAL_W-1:0]  deadline;
		logic                last_job;
	} job_t;

	typedef struct packed {
		logic [COUNT_OUT_W-1:0] kept_count;
		logic                   evicted_valid;
		logic [DUR_IN_W-1:0]    evicted_duration;
		logic                   overflow;
		logic                   set_done;
	} res_t;

	// operation broadcast to every cell of the sorted row
	typedef struct packed {
		logic ins;
		logic clr;
		logic pop;
	} cell_ctrl_t;

	typedef enum logic {
		ST_IDLE,
		ST_POP
	} state_t;

endpackage

/* rtl/deadline_greedy_job_selector_top.sv */
// Greedy deadline job selector.
// Jobs enter on the job channel (job_valid / job_stall / job), results leave on
// the res channel (res_valid / res_stall / res), one result per job, in order.
// Kept durations sit in a row of cells sorted longest first. On the job
// transfer the duration is inserted into the row, the late test (running
// total above deadline) is taken and the total is updated. In the evict
// state that follows, once the output register is empty or not stalled, the
// longest duration is shifted out of the row head if the job was late, and
// the result is loaded into the output register that drives res_valid.
// job_stall is high in the evict state, so a new job is not taken until the
// previous job has left it.
// A job marked last_job closes its set; the next job clears the row in the
// same cycle as its insert. With the row full a job is rejected with overflow.
// The next job is taken while a result waits in the output register; if the
// receiver keeps stalling, the following result holds the row in its evict
// cycle and job_stall stays high. Reset empties the row and all counters.
module deadline_greedy_job_selector_top #(
	parameter int MAX_JOBS      = dgjs_pkg::MAX_JOBS_DEF,
	parameter int DURATION_BITS = dgjs_pkg::DURATION_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	output logic           job_stall,
	input  dgjs_pkg::job_t job,
	output logic           res_valid,
	input  logic           res_stall,
	output dgjs_pkg::res_t res
);

	localparam int CNT_W = $clog2(MAX_JOBS + 1);

	dgjs_pkg::state_t     state_q, state_d;
	dgjs_pkg::cell_ctrl_t ctrl;

	logic [CNT_W-1:0]             count_q, cnt_eff;
	logic [dgjs_pkg::TOTAL_W-1:0] total_q, tot_eff;
	logic                         clear_next_q;
	logic                         late_q;
	logic                         ovf_q;
	logic                         last_q;
	logic                         out_valid_q;
	dgjs_pkg::res_t               out_q;

	logic                     accept, pop_fire, full;
	logic [DURATION_BITS-1:0] new_value, head_value;

	assign cnt_eff   = clear_next_q ? '0 : count_q;
	assign tot_eff   = clear_next_q ? '0 : total_q;
	assign full      = (cnt_eff == CNT_W'(MAX_JOBS));
	assign new_value = DURATION_BITS'(job.duration);

	always_comb begin
		state_d  = state_q;
		accept   = 1'b0;
		pop_fire = 1'b0;
		case (state_q)
			dgjs_pkg::ST_IDLE: begin
				if (job_valid) begin
					accept  = 1'b1;
					state_d = dgjs_pkg::ST_POP;
				end
			end
			dgjs_pkg::ST_POP: begin
				if (!out_valid_q || !res_stall) begin
					pop_fire = 1'b1;
					state_d  = dgjs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dgjs_pkg::ST_IDLE;
			end
		endcase
	end

	assign job_stall = (state_q != dgjs_pkg::ST_IDLE);
	assign ctrl.ins  = accept & ~full;
	assign ctrl.clr  = accept & clear_next_q;
	assign ctrl.pop  = pop_fire & late_q;

	dgjs_chain #(
		.MAX_JOBS     (MAX_JOBS),
		.DURATION_BITS(DURATION_BITS)
	) u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.new_value (new_value),
		.head_value(head_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= dgjs_pkg::ST_IDLE;
			count_q      <= '0;
			total_q      <= '0;
			clear_next_q <= 1'b0;
			late_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				clear_next_q <= job.last_job;
				late_q       <= ~full & (tot_eff > job.deadline);
				if (full) begin
					count_q <= cnt_eff;
					total_q <= tot_eff;
				end else begin
					count_q <= cnt_eff + CNT_W'(1);
					total_q <= tot_eff + dgjs_pkg::TOTAL_W'(new_value);
				end
			end else if (pop_fire && late_q) begin
				count_q <= count_q - CNT_W'(1);
				total_q <= total_q - dgjs_pkg::TOTAL_W'(head_value);
			end
			if (pop_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !res_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ovf_q  <= full;
			last_q <= job.last_job;
		end
		if (pop_fire) begin
			out_q.kept_count       <= late_q ? dgjs_pkg::COUNT_OUT_W'(count_q - CNT_W'(1))
			                                 : dgjs_pkg::COUNT_OUT_W'(count_q);
			out_q.evicted_valid    <= late_q;
			out_q.evicted_duration <= late_q ? dgjs_pkg::DUR_IN_W'(head_value) : '0;
			out_q.overflow         <= ovf_q;
			out_q.set_done         <= last_q;
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

endmodule

/* rtl/dgjs_cell.sv */
module dgjs_cell #(
	parameter int DURATION_BITS = dgjs_pkg::DURATION_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  dgjs_pkg::cell_ctrl_t     ctrl,
	input  logic [DURATION_BITS-1:0] new_value,
	input  logic                     prev_gt,
	input  logic [DURATION_BITS-1:0] prev_value,
	input  logic                     prev_valid,
	input  logic [DURATION_BITS-1:0] next_value,
	input  logic                     next_valid,
	output logic [DURATION_BITS-1:0] value,
	output logic                     valid,
	output logic                     gt
);

	logic [DURATION_BITS-1:0] value_q;
	logic                     valid_q;
	logic                     valid_eff;

	// a new set drops all contents in the same cycle as its first insert
	assign valid_eff = valid_q & ~ctrl.clr;
	assign gt        = ~valid_eff | (new_value > value_q);
	assign value     = value_q;
	assign valid     = valid_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.ins) begin
			if (gt) begin
				valid_q <= prev_gt ? prev_valid : 1'b1;
			end else begin
				valid_q <= valid_eff;
			end
		end else if (ctrl.pop) begin
			valid_q <= next_valid;
		end
	end

	// descending order: shift right on insert, left on pop
	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (gt) begin
				value_q <= prev_gt ? prev_value : new_value;
			end
		end else if (ctrl.pop) begin
			value_q <= next_value;
		end
	end

endmodule

/* rtl/dgjs_chain.sv */
module dgjs_chain #(
	parameter int MAX_JOBS      = dgjs_pkg::MAX_JOBS_DEF,
	parameter int DURATION_BITS = dgjs_pkg::DURATION_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  dgjs_pkg::cell_ctrl_t     ctrl,
	input  logic [DURATION_BITS-1:0] new_value,
	output logic [DURATION_BITS-1:0] head_value
);

	logic [DURATION_BITS-1:0] val [MAX_JOBS];
	logic                     vld [MAX_JOBS];
	logic                     gt  [MAX_JOBS];

	for (genvar i = 0; i < MAX_JOBS; i++) begin : g_cell
		logic                     p_gt;
		logic [DURATION_BITS-1:0] p_val;
		logic                     p_vld;
		logic [DURATION_BITS-1:0] n_val;
		logic                     n_vld;

		if (i == 0) begin : g_first
			assign p_gt  = 1'b0;
			assign p_val = '0;
			assign p_vld = 1'b0;
		end else begin : g_mid
			assign p_gt  = gt[i-1];
			assign p_val = val[i-1];
			assign p_vld = vld[i-1];
		end

		if (i == MAX_JOBS-1) begin : g_last
			assign n_val = '0;
			assign n_vld = 1'b0;
		end else begin : g_inner
			assign n_val = val[i+1];
			assign n_vld = vld[i+1];
		end

		dgjs_cell #(
			.DURATION_BITS(DURATION_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.new_value (new_value),
			.prev_gt   (p_gt),
			.prev_value(p_val),
			.prev_valid(p_vld),
			.next_value(n_val),
			.next_valid(n_vld),
			.value     (val[i]),
			.valid     (vld[i]),
			.gt        (gt[i])
		);
	end

	assign head_value = val[0];

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;

	localparam int          JOB_CAP     = dgjs_pkg::MAX_JOBS_DEF;
	localparam int          ITEM_TARGET = 1850;
	localparam int          HOLD_CYCLES = 300;
	localparam int          QUIET_LIMIT = 2000;
	localparam logic [47:0] DL_MAX      = 48'hFFFF_FFFF_FFFF;
	localparam logic [31:0] DUR_MAX     = 32'hFFFF_FFFF;

	logic           clk       = 1'b0;
	logic           arst_n    = 1'b0;
	logic           job_valid = 1'b0;
	logic           res_stall = 1'b0;
	dgjs_pkg::job_t job       = '0;
	logic           job_stall;
	logic           res_valid;
	dgjs_pkg::res_t res;

	// scheduler state as the block should hold it
	logic [31:0] held_durations[$];
	logic [47:0] held_total  = '0;
	bit          set_closed  = 1'b0;

	dgjs_pkg::res_t pending_results[$];
	int   fail_count   = 0;
	int   jobs_sent    = 0;
	int   quiet_cycles = 0;
	int   hold_request = 0;
	bit   tx_idle      = 1'b1;
	bit   rx_idle      = 1'b1;

	deadline_greedy_job_selector_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job_stall (job_stall),
		.job       (job),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic dgjs_pkg::res_t schedule_job(input dgjs_pkg::job_t j);
		dgjs_pkg::res_t r;
		bit   late;
		int   best;
		r = '0;
		if (set_closed) begin
			held_durations.delete();
			held_total = '0;
		end
		if (held_durations.size() >= JOB_CAP) begin
			r.overflow = 1'b1;
		end else begin
			// old total above deadline is the same test as new total above deadline + duration
			late = held_total > j.deadline;
			held_durations.insert(held_durations.size(), j.duration);
			held_total = held_total + 48'(j.duration);
			if (late) begin
				best = 0;
				foreach (held_durations[i])
					if (held_durations[i] > held_durations[best])
						best = i;
				r.evicted_valid    = 1'b1;
				r.evicted_duration = held_durations[best];
				held_total = held_total - 48'(held_durations[best]);
				held_durations.delete(best);
			end
		end
		set_closed = j.last_job;
		r.kept_count = 9'(held_durations.size());
		r.set_done   = j.last_job;
		return r;
	endfunction

	function automatic dgjs_pkg::job_t make_job(input logic [31:0] dur,
			input logic [47:0] dl, input bit last);
		dgjs_pkg::job_t j;
		j.duration = dur;
		j.deadline = dl;
		j.last_job = last;
		return j;
	endfunction

	// deadlines are mostly placed around the running total so both outcomes occur
	function automatic dgjs_pkg::job_t random_job(input bit fill, input bit last);
		logic [31:0] dur;
		logic [47:0] dl;
		logic [47:0] cur;
		int          pick;
		cur  = set_closed ? 48'd0 : held_total;
		pick = int'($urandom_range(0, 9));
		case (pick)
			0:       dur = '0;
			1:       dur = DUR_MAX;
			2, 3, 4: dur = $urandom;
			default: dur = $urandom_range(0, 50);
		endcase
		pick = fill ? 10 : int'($urandom_range(0, 9));
		case (pick)
			0:          dl = '0;
			1:          dl = DL_MAX;
			2:          dl = 48'({$urandom, $urandom});
			3, 4, 5, 6: dl = (cur + 48'($urandom_range(0, 16)) >= 48'd8) ?
					cur + 48'($urandom_range(0, 16)) - 48'd8 : 48'd0;
			7, 8, 9:    dl = cur + 48'($urandom_range(0, 200));
			default:    dl = cur + 48'($urandom);
		endcase
		return make_job(dur, dl, last);
	endfunction

	task automatic offer_job(input dgjs_pkg::job_t j);
		int gap;
		gap = tx_idle ? int'($urandom_range(0, 12)) : 0;
		if (gap > 0) begin
			job_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		job_valid <= 1'b1;
		job       <= j;
		do @(posedge clk); while (job_stall);
		pending_results.insert(pending_results.size(), schedule_job(j));
		jobs_sent++;
	endtask

	task automatic wait_drained();
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		offer_job(make_job(32'd0, 48'd0, 1'b0));
		offer_job(make_job(DUR_MAX, 48'd0, 1'b0));
		// late: evicts the longest held job
		offer_job(make_job(32'd5, 48'd0, 1'b0));
		offer_job(make_job(DUR_MAX, DL_MAX, 1'b0));
		// late with a tie on the longest duration
		offer_job(make_job(DUR_MAX, 48'd0, 1'b0));
		offer_job(make_job(32'd1, 48'd0, 1'b1));
		// new set starts from an empty row
		offer_job(make_job(32'd7, 48'd0, 1'b0));
		offer_job(make_job(32'd3, 48'd6, 1'b0));
		offer_job(make_job(32'd3, 48'd3, 1'b0));
		// the job just added is the longest and is the one evicted
		offer_job(make_job(32'd100, 48'd0, 1'b0));
		offer_job(make_job(32'd3, 48'd0, 1'b0));
		offer_job(make_job(32'd3, 48'd6, 1'b1));
		offer_job(make_job(32'd9, 48'd0, 1'b1));
		offer_job(make_job(32'd9, 48'd0, 1'b1));
		offer_job(make_job(32'h5555_5555, 48'hAAAA_AAAA_AAAA, 1'b0));
		offer_job(make_job(32'hAAAA_AAAA, 48'h5555_5555_5555, 1'b0));
		offer_job(make_job(32'h8000_0000, 48'h8000_0000_0000, 1'b0));
		offer_job(make_job(32'h0000_0001, 48'h0000_0000_0001, 1'b1));
	endtask

	task automatic test_store_full();
		int k;
		for (k = 0; k < JOB_CAP + 2; k++)
			offer_job(make_job($urandom, DL_MAX, 1'b0));
		// rejected even though it would be late
		offer_job(make_job(32'd4, 48'd0, 1'b0));
		offer_job(make_job(DUR_MAX, DL_MAX, 1'b1));
		offer_job(make_job(32'd2, 48'd0, 1'b0));
	endtask

	task automatic test_back_to_back();
		int k;
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		for (k = 0; k < 60; k++)
			offer_job(random_job(1'b0, $urandom_range(0, 7) == 0));
		tx_idle = 1'b1;
		rx_idle = 1'b1;
	endtask

	task automatic test_output_hold();
		int k;
		tx_idle      = 1'b0;
		hold_request = HOLD_CYCLES;
		for (k = 0; k < 24; k++)
			offer_job(random_job(1'b0, k == 23));
		tx_idle = 1'b1;
	endtask

	task automatic test_drain_pause();
		int k;
		int n;
		for (n = 0; n < 4; n++) begin
			for (k = 0; k < 6; k++)
				offer_job(random_job(1'b0, $urandom_range(0, 5) == 0));
			job_valid <= 1'b0;
			wait_drained();
		end
	endtask

	task automatic test_random_sets();
		int  set_len;
		int  k;
		bit  fill;
		while (jobs_sent < ITEM_TARGET) begin
			tx_idle = $urandom_range(0, 3) != 0;
			rx_idle = $urandom_range(0, 3) != 0;
			fill    = $urandom_range(0, 24) == 0;
			set_len = fill ? int'($urandom_range(250, 270)) : int'($urandom_range(1, 30));
			for (k = 0; k < set_len; k++)
				offer_job(random_job(fill, k == set_len - 1));
		end
		tx_idle = 1'b1;
		rx_idle = 1'b1;
	endtask

	// result side: random stall per result, plus a long hold when asked
	initial begin : result_sink
		int wait_cycles;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_request > 0) begin
				wait_cycles  = hold_request;
				hold_request = 0;
			end else begin
				wait_cycles = rx_idle ? int'($urandom_range(0, 12)) : 0;
			end
			if (wait_cycles > 0) begin
				res_stall <= 1'b1;
				repeat (wait_cycles) @(posedge clk);
			end
			res_stall <= 1'b0;
			do @(posedge clk); while (!res_valid);
		end
	end

	always @(posedge clk) begin : check_results
		dgjs_pkg::res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_results.size() == 0) begin
				$error("result with no job pending: %p", res);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (res.kept_count !== want.kept_count) begin
					$error("kept_count: expected %0d, got %0d", want.kept_count, res.kept_count);
					fail_count++;
				end
				if (res.evicted_valid !== want.evicted_valid) begin
					$error("evicted_valid: expected %0d, got %0d", want.evicted_valid,
						res.evicted_valid);
					fail_count++;
				end
				if (res.evicted_duration !== want.evicted_duration) begin
					$error("evicted_duration: expected %0h, got %0h", want.evicted_duration,
						res.evicted_duration);
					fail_count++;
				end
				if (res.overflow !== want.overflow) begin
					$error("overflow: expected %0d, got %0d", want.overflow, res.overflow);
					fail_count++;
				end
				if (res.set_done !== want.set_done) begin
					$error("set_done: expected %0d, got %0d", want.set_done, res.set_done);
					fail_count++;
				end
			end
		end
	end

	// any transfer on either side restarts the count
	always @(posedge clk) begin
		if (!arst_n || (job_valid && !job_stall) || (res_valid && !res_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_store_full();
		test_back_to_back();
		test_output_hold();
		test_drain_pause();
		test_random_sets();
		job_valid <= 1'b0;
		wait_drained();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

/* filelist.f */
rtl/dgjs_pkg.sv
rtl/dgjs_cell.sv
rtl/dgjs_chain.sv
rtl/deadline_greedy_job_selector_top.sv
test/testbench.sv
